// ===== hdl/vdct_pkg.sv =====
// ----------------------------------------------------------------------------
// vdct_pkg: shared types and constants
// Field widths, register indexes and the sequencer state type of the
// vertex welding table.
// ----------------------------------------------------------------------------
package vdct_pkg;

    localparam int IDX_W     = 14;
    localparam int POS_W     = 32;
    localparam int DIR_W     = 48;
    localparam int LANE_W    = 16;
    localparam int TEX_W     = 32;
    localparam int NUM_W     = 14;
    localparam int DIR_TOL_W = 15;
    localparam int TEX_TOL_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DIR_TOL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_TOL = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_HEAD = 4'b0010,
        ST_WALK = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

endpackage

// ===== hdl/vdct_if.sv =====
// ----------------------------------------------------------------------------
// vdct_if: channel interfaces
// Vertex input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface dedup_in_if;
    logic               valid;
    logic               ready;
    logic [13:0]        src_index;
    logic [31:0]        pos_x;
    logic [31:0]        pos_y;
    logic [31:0]        pos_z;
    logic [47:0]        normal_packed;
    logic [47:0]        tangent_packed;
    logic               tangent_sign;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic               start_mesh;

    modport source (output valid, src_index, pos_x, pos_y, pos_z, normal_packed,
                    tangent_packed, tangent_sign, tex_u, tex_v, start_mesh, input ready);
    modport sink   (input valid, src_index, pos_x, pos_y, pos_z, normal_packed,
                    tangent_packed, tangent_sign, tex_u, tex_v, start_mesh, output ready);
endinterface

interface dedup_out_if;
    logic        valid;
    logic        ready;
    logic [13:0] vertex_number;
    logic        is_new;
    logic        overflow;

    modport source (output valid, vertex_number, is_new, overflow, input ready);
    modport sink   (input valid, vertex_number, is_new, overflow, output ready);
endinterface

interface dedup_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/vdct_ram.sv =====
// ----------------------------------------------------------------------------
// vdct_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module vdct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/vertex_dedup_chain_table_core.sv =====
// ----------------------------------------------------------------------------
// vertex_dedup_chain_table_core: mesh vertex welding table
// Welds face-corner vertices into unique vertices through per-index chains.
// ----------------------------------------------------------------------------
// Usage:
//   vtx : one face-corner vertex per item. ready is high only while the
//         sequencer is idle, so one item is worked on at a time.
//   res : one result per item (vertex_number, is_new, overflow), held in an
//         output register until taken. A new item may be accepted while a
//         result still waits there.
//   cfg : register writes (index 0 direction tolerance, 1 texcoord
//         tolerance); always ready, write only while idle.
// Steps: an item is accepted while idle, then takes one head read, one node
//   read per chain node visited (at least one when the chain is live) and
//   one finish state. The next item is accepted only after the finish.
// Chains live in a head memory; nodes in a node memory that also keeps each
//   node's source index. A head is trusted only if it points below the node
//   count at a node of the same source index, so start of mesh and reset
//   just zero the count; no clearing pass is needed.
// Reset clears the sequencer, node count, tolerances and the output valid.
// A stalled receiver holds the result; the sequencer waits in its finish
//   state, without writing, until the output register is free.
// ----------------------------------------------------------------------------
module vertex_dedup_chain_table_core #(
    parameter int SOURCE_VERTICES = 16384,
    parameter int NODE_CAPACITY   = 16384
) (
    input  logic        clk,
    input  logic        rst_n,
    dedup_in_if.sink    vtx,
    dedup_out_if.source res,
    dedup_cfg_if.sink   cfg
);

    import vdct_pkg::*;

    localparam int SRC_W   = $clog2(SOURCE_VERTICES);
    localparam int NODE_AW = $clog2(NODE_CAPACITY);
    localparam int PTR_W   = NODE_AW + 1;
    localparam int NODE_W  = SRC_W + PTR_W + 3 * POS_W + DIR_W + 1 + DIR_W + 2 * TEX_W;
    localparam logic [PTR_W-1:0] END_MARK = PTR_W'(NODE_CAPACITY);

    // Sequencer and item registers
    state_t                state_reg, state_next;
    logic [SRC_W-1:0]      src_reg, src_next;
    logic [POS_W-1:0]      px_reg, py_reg, pz_reg;
    logic [DIR_W-1:0]      nrm_reg, tan_reg;
    logic                  tsg_reg;
    logic [TEX_W-1:0]      tu_reg, tv_reg;
    logic [PTR_W-1:0]      cur_reg, cur_next;
    logic [PTR_W-1:0]      link_reg, link_next;
    logic                  first_reg, first_next;
    logic                  match_reg, match_next;
    logic [PTR_W-1:0]      count_reg, count_next;
    logic [DIR_TOL_W-1:0]  dir_tol_reg;
    logic [TEX_TOL_W-1:0]  tex_tol_reg;

    // Output register
    logic                  res_valid_reg, res_valid_next;
    logic [NUM_W-1:0]      res_num_reg, res_num_next;
    logic                  res_new_reg, res_new_next;
    logic                  res_ovf_reg, res_ovf_next;

    // Memory ports
    logic [SRC_W-1:0]      head_raddr;
    logic [PTR_W-1:0]      head_rdata;
    logic                  head_we;
    logic [NODE_AW-1:0]    node_raddr;
    logic [NODE_W-1:0]     node_rdata;
    logic [NODE_W-1:0]     node_wdata;
    logic                  node_we;

    // Unpacked node fields
    logic [SRC_W-1:0]      nd_src;
    logic [PTR_W-1:0]      nd_next;
    logic [POS_W-1:0]      nd_px, nd_py, nd_pz;
    logic [DIR_W-1:0]      nd_nrm, nd_tan;
    logic                  nd_tsg;
    logic [TEX_W-1:0]      nd_tu, nd_tv;

    logic                  vtx_fire;
    logic                  res_free;
    logic                  node_match;
    logic [SRC_W-1:0]      src_in;

    assign vtx.ready = (state_reg == ST_IDLE);
    assign vtx_fire  = vtx.valid && vtx.ready;
    assign cfg.ready = 1'b1;
    assign res_free  = !res_valid_reg || res.ready;
    assign src_in    = SRC_W'(32'(vtx.src_index) % SOURCE_VERTICES);

    assign res.valid         = res_valid_reg;
    assign res.vertex_number = res_num_reg;
    assign res.is_new        = res_new_reg;
    assign res.overflow      = res_ovf_reg;

    assign {nd_src, nd_next, nd_px, nd_py, nd_pz, nd_nrm, nd_tsg, nd_tan, nd_tv, nd_tu}
        = node_rdata;
    assign node_wdata = {src_reg, link_reg, px_reg, py_reg, pz_reg, nrm_reg, tsg_reg,
                         tan_reg, tv_reg, tu_reg};

    vdct_ram #(.WIDTH(PTR_W), .DEPTH(SOURCE_VERTICES)) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (src_reg),
        .wdata (count_reg),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    vdct_ram #(.WIDTH(NODE_W), .DEPTH(NODE_CAPACITY)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (count_reg[NODE_AW-1:0]),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    // Attribute compare against the node read this cycle
    function automatic logic dir_close(input logic [DIR_W-1:0] a, input logic [DIR_W-1:0] b,
                                       input logic [DIR_TOL_W-1:0] tol);
        logic signed [LANE_W:0] d;
        logic [LANE_W:0]        m;
        logic                   ok;
        ok = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            d = $signed({a[k*LANE_W+LANE_W-1], a[k*LANE_W +: LANE_W]})
                - $signed({b[k*LANE_W+LANE_W-1], b[k*LANE_W +: LANE_W]});
            m = d[LANE_W] ? (LANE_W+1)'(-d) : (LANE_W+1)'(d);
            if (m > (LANE_W+1)'(tol))
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic logic tex_close(input logic [TEX_W-1:0] a, input logic [TEX_W-1:0] b,
                                       input logic [TEX_TOL_W-1:0] tol);
        logic signed [TEX_W:0] d;
        logic [TEX_W:0]        m;
        d = $signed({a[TEX_W-1], a}) - $signed({b[TEX_W-1], b});
        m = d[TEX_W] ? (TEX_W+1)'(-d) : (TEX_W+1)'(d);
        return m <= (TEX_W+1)'(tol);
    endfunction

    assign node_match = (nd_px == px_reg) && (nd_py == py_reg) && (nd_pz == pz_reg)
                     && (nd_tsg == tsg_reg)
                     && dir_close(nrm_reg, nd_nrm, dir_tol_reg)
                     && dir_close(tan_reg, nd_tan, dir_tol_reg)
                     && tex_close(tu_reg, nd_tu, tex_tol_reg)
                     && tex_close(tv_reg, nd_tv, tex_tol_reg);

    always_comb
    begin
        state_next     = state_reg;
        src_next       = src_reg;
        cur_next       = cur_reg;
        link_next      = link_reg;
        first_next     = first_reg;
        match_next     = match_reg;
        count_next     = count_reg;
        res_valid_next = res_valid_reg && !res.ready;
        res_num_next   = res_num_reg;
        res_new_next   = res_new_reg;
        res_ovf_next   = res_ovf_reg;
        head_raddr     = src_in;
        node_raddr     = head_rdata[NODE_AW-1:0];
        head_we        = 1'b0;
        node_we        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (vtx_fire)
                begin
                    src_next   = src_in;
                    state_next = ST_HEAD;
                    // start of mesh: empty every chain by dropping the count
                    if (vtx.start_mesh)
                    begin
                        count_next = '0;
                    end
                end
            end
            ST_HEAD:
            begin
                // trust the head only if it points at a node of this mesh
                if (head_rdata < count_reg)
                begin
                    cur_next   = head_rdata;
                    link_next  = head_rdata;
                    first_next = 1'b1;
                    state_next = ST_WALK;
                end
                else
                begin
                    link_next  = END_MARK;
                    match_next = 1'b0;
                    state_next = ST_FIN;
                end
            end
            ST_WALK:
            begin
                node_raddr = nd_next[NODE_AW-1:0];
                if (first_reg && (nd_src != src_reg))
                begin
                    // stale head left from an earlier mesh
                    link_next  = END_MARK;
                    match_next = 1'b0;
                    state_next = ST_FIN;
                end
                else if (node_match)
                begin
                    match_next = 1'b1;
                    state_next = ST_FIN;
                end
                else if (nd_next < count_reg)
                begin
                    cur_next   = nd_next;
                    first_next = 1'b0;
                end
                else
                begin
                    match_next = 1'b0;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (match_reg)
                    begin
                        res_num_next = NUM_W'(cur_reg);
                        res_new_next = 1'b0;
                        res_ovf_next = 1'b0;
                    end
                    else if (count_reg >= END_MARK)
                    begin
                        res_num_next = '0;
                        res_new_next = 1'b0;
                        res_ovf_next = 1'b1;
                    end
                    else
                    begin
                        // append at the count and link at the chain head
                        node_we      = 1'b1;
                        head_we      = 1'b1;
                        count_next   = count_reg + PTR_W'(1);
                        res_num_next = NUM_W'(count_reg);
                        res_new_next = 1'b1;
                        res_ovf_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            dir_tol_reg   <= '0;
            tex_tol_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_DIR_TOL: dir_tol_reg <= cfg.data[DIR_TOL_W-1:0];
                    REG_TEX_TOL: tex_tol_reg <= cfg.data[TEX_TOL_W-1:0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg     <= src_next;
        cur_reg     <= cur_next;
        link_reg    <= link_next;
        first_reg   <= first_next;
        match_reg   <= match_next;
        res_num_reg <= res_num_next;
        res_new_reg <= res_new_next;
        res_ovf_reg <= res_ovf_next;
        if (vtx_fire)
        begin
            px_reg  <= vtx.pos_x;
            py_reg  <= vtx.pos_y;
            pz_reg  <= vtx.pos_z;
            nrm_reg <= vtx.normal_packed;
            tan_reg <= vtx.tangent_packed;
            tsg_reg <= vtx.tangent_sign;
            tu_reg  <= vtx.tex_u;
            tv_reg  <= vtx.tex_v;
        end
    end

endmodule

// ===== hdl/vdct_checker.sv =====
// ----------------------------------------------------------------------------
// vdct_checker: port-level checks
// Watches the top level's channels and is bound to it.
// ----------------------------------------------------------------------------
module vdct_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        vtx_valid,
    input logic        vtx_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [13:0] res_number,
    input logic        res_new,
    input logic        res_ovf
);

    // hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // overflow carries no vertex
    a_ovf_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ovf |-> !res_new && (res_number == 14'd0))
        else $error("overflow result malformed");

    // one item in flight: no accept right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_valid && vtx_ready |=> !vtx_ready)
        else $error("second item accepted while busy");

    // no result becomes valid right after an accept made with no result waiting
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_valid && vtx_ready && !res_valid |=> !res_valid)
        else $error("result too early");

endmodule

bind vertex_dedup_chain_table_core vdct_checker u_vdct_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .vtx_valid  (vtx.valid),
    .vtx_ready  (vtx.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_number (res.vertex_number),
    .res_new    (res.is_new),
    .res_ovf    (res.overflow)
);
